>>> design/tga_image_stream_decoder_unit_defines.svh
`ifndef TGA_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH
`define TGA_IMAGE_STREAM_DECODER_UNIT_DEFINES_SVH

// clocked check of a property, off while in reset
`define TGAD_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// clocked check that a condition never holds
`define TGAD_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);

`endif

>>> design/tgad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgad_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int HDR_BYTES       = 18;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW         = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0]  MODE_MASK      = 3'h7;
	localparam logic [2:0]  MODE_CMAP      = 3'd1;
	localparam logic [2:0]  MODE_TRUECOLOR = 3'd2;
	localparam logic [7:0]  DEPTH_8        = 8'd8;
	localparam logic [7:0]  DEPTH_24       = 8'd24;
	localparam logic [7:0]  DEPTH_32       = 8'd32;
	localparam logic [31:0] ALPHA_OPAQUE   = 32'hFF000000;

	typedef enum logic [2:0] {
		KIND_RUN     = 3'd0,
		KIND_DONE    = 3'd1,
		KIND_HEADER  = 3'd2,
		KIND_PALETTE = 3'd3,
		KIND_TRUNC   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] color;
		logic [15:0] dest_row;
		logic [15:0] dest_col;
		logic [7:0]  run_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] s1_cnt;
	} stat_t;

	function automatic res_t fin_res(kind_t k, logic [15:0] w, logic [15:0] h);
		res_t r;
		r              = '0;
		r.kind         = k;
		r.image_width  = w;
		r.image_height = h;
		r.last         = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/tgad_palette_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tgad_palette_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [tgad_pkg::PAL_AW-1:0] waddr,
	input  wire logic [31:0]                wdata,
	input  wire logic                       re,
	input  wire logic [tgad_pkg::PAL_AW-1:0] raddr,
	output logic [31:0]                     rdata
);
	import tgad_pkg::*;

	logic [31:0] mem [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/tgad_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tgad_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_take,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        stream_last,
	output logic                             pal_we,
	output logic [tgad_pkg::PAL_AW-1:0]      pal_waddr,
	output logic [31:0]                      pal_wdata,
	output logic                             pal_re,
	output logic [tgad_pkg::PAL_AW-1:0]      pal_raddr,
	input  wire logic [31:0]                 pal_rdata,
	output tgad_pkg::res_t                   res0,
	output tgad_pkg::res_t                   res1,
	output tgad_pkg::stat_t                  stat
);
	import tgad_pkg::*;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_PALETTE = 5'b00010,
		PH_PACKET  = 5'b00100,
		PH_PIXEL   = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [4:0]  hcnt_q, hcnt_n;
	logic [1:0]  sub_q, sub_n;
	logic [8:0]  ent_q, ent_n;
	logic [7:0]  id_q, id_n, type_q, type_n, cmd_q, cmd_n, pd_q, pd_n, desc_q, desc_n;
	logic [15:0] cms_q, cms_n, cml_q, cml_n, w_q, w_n, h_q, h_n;
	logic [31:0] cass_q, cass_n, left_q, left_n, total_q;
	logic [7:0]  prem_q, prem_n;
	logic        prun_q, prun_n;
	logic [15:0] row_q, row_n;
	logic [16:0] col_q, col_n;

	res_t        r0_s1, r1_s1;
	logic [1:0]  cnt_s1;
	logic        pal_s1, palz_s1;

	res_t        rq [2];
	res_t        rr;
	logic [1:0]  n;
	logic        pal_n, palz_n;
	logic        busy, fmt_ok, start, show;
	logic [31:0] cass_new, pcolor;
	logic [1:0]  last_sub;
	logic [7:0]  lreq, len;
	logic [16:0] ncol;

	assign busy = (phase_q == PH_PACKET || phase_q == PH_PIXEL) && (col_q >= {1'b0, w_q});
	assign fmt_ok = (pd_q == DEPTH_32 && (type_q[2:0] & MODE_MASK) == MODE_TRUECOLOR)
		|| (pd_q == DEPTH_24 && type_q[2:0] == MODE_TRUECOLOR && !type_q[3])
		|| (pd_q == DEPTH_8 && type_q[2:0] == MODE_CMAP && !type_q[3]);
	assign cass_new = cass_q | (32'(data_byte) << {sub_q, 3'b000});
	assign last_sub = (pd_q == DEPTH_8) ? 2'd0 : ((pd_q == DEPTH_24) ? 2'd2 : 2'd3);

	always_comb begin
		phase_n = phase_q; hcnt_n = hcnt_q; sub_n = sub_q; ent_n = ent_q;
		id_n = id_q; type_n = type_q; cmd_n = cmd_q; pd_n = pd_q; desc_n = desc_q;
		cms_n = cms_q; cml_n = cml_q; w_n = w_q; h_n = h_q;
		cass_n = cass_q; left_n = left_q; prem_n = prem_q; prun_n = prun_q;
		row_n = row_q; col_n = col_q;
		rq[0] = '0; rq[1] = '0; rr = '0; n = 2'd0;
		pal_n = 1'b0; palz_n = 1'b0; start = 1'b0; show = 1'b0;
		pal_we = 1'b0; pal_waddr = ent_q[PAL_AW-1:0]; pal_wdata = ALPHA_OPAQUE | cass_new;
		pal_re = 1'b0; pal_raddr = data_byte[PAL_AW-1:0];
		pcolor = cass_new; lreq = 8'd1; len = 8'd1; ncol = '0;
		if (busy) begin
			// fold the column back into range, one row per cycle
			col_n = col_q - {1'b0, w_q};
			row_n = row_q + 16'd1;
		end else if (in_take) begin
			unique case (phase_q)
				PH_HEADER: begin
					case (hcnt_q)
						5'd0:  id_n = data_byte;
						5'd2:  type_n = data_byte;
						5'd3:  cms_n[7:0] = data_byte;
						5'd4:  cms_n[15:8] = data_byte;
						5'd5:  cml_n[7:0] = data_byte;
						5'd6:  cml_n[15:8] = data_byte;
						5'd7:  cmd_n = data_byte;
						5'd12: w_n[7:0] = data_byte;
						5'd13: w_n[15:8] = data_byte;
						5'd14: h_n[7:0] = data_byte;
						5'd15: h_n[15:8] = data_byte;
						5'd16: pd_n = data_byte;
						5'd17: desc_n = data_byte;
						default: ;
					endcase
					hcnt_n = hcnt_q + 5'd1;
					if (hcnt_q == 5'(HDR_BYTES - 1)) begin
						if (id_q != 8'd0 || !fmt_ok) begin
							rq[n[0]] = fin_res(KIND_HEADER, 16'd0, 16'd0); n = n + 2'd1;
							phase_n = PH_SKIP;
						end else if (pd_q == DEPTH_8 && (cms_q != 16'd0
								|| cml_q > 16'(PALETTE_ENTRIES) || cmd_q != DEPTH_24)) begin
							rq[n[0]] = fin_res(KIND_PALETTE, 16'd0, 16'd0); n = n + 2'd1;
							phase_n = PH_SKIP;
						end else if (pd_q == DEPTH_8 && cml_q != 16'd0) begin
							phase_n = PH_PALETTE;
							ent_n = '0; sub_n = '0; cass_n = '0;
						end else begin
							start = 1'b1;
						end
					end
				end
				PH_PALETTE: begin
					cass_n = cass_new;
					if (sub_q == 2'd2) begin
						pal_we = 1'b1;
						cass_n = '0; sub_n = '0;
						ent_n = ent_q + 9'd1;
						if (16'(ent_q) + 16'd1 == cml_q) begin
							start = 1'b1; show = 1'b1;
						end
					end else begin
						sub_n = sub_q + 2'd1;
					end
				end
				PH_PACKET: begin
					prun_n = data_byte[7];
					prem_n = {1'b0, data_byte[6:0]} + 8'd1;
					sub_n = '0; cass_n = '0;
					phase_n = PH_PIXEL;
				end
				PH_PIXEL: begin
					cass_n = cass_new;
					sub_n = sub_q + 2'd1;
					if (sub_q == last_sub) begin
						sub_n = '0; cass_n = '0;
						if (pd_q == DEPTH_8) begin
							pal_re = 1'b1; pal_n = 1'b1;
							palz_n = !((16'(data_byte) < cml_q)
								&& (9'(data_byte) < 9'(PALETTE_ENTRIES)));
							pcolor = '0;
						end else if (pd_q == DEPTH_24) begin
							pcolor = ALPHA_OPAQUE | {8'd0, cass_new[23:0]};
						end
						if (type_q[3] && prun_q) lreq = prem_q;
						len = (32'(lreq) > left_q) ? left_q[7:0] : lreq;
						rr.kind = KIND_RUN;
						rr.color = pcolor;
						rr.dest_row = desc_q[5] ? row_q : (h_q - 16'd1 - row_q);
						rr.dest_col = col_q[15:0];
						rr.run_length = len;
						rr.image_width = w_q;
						rr.image_height = h_q;
						rq[n[0]] = rr; n = n + 2'd1;
						left_n = left_q - 32'(len);
						ncol = col_q + 17'(len);
						if (ncol >= {1'b0, w_q}) begin
							col_n = ncol - {1'b0, w_q};
							row_n = row_q + 16'd1;
						end else begin
							col_n = ncol;
						end
						if (left_n == 32'd0) begin
							rq[n[0]] = fin_res(KIND_DONE, w_q, h_q); n = n + 2'd1;
							phase_n = PH_SKIP;
						end
						if (type_q[3]) begin
							if (prun_q) prem_n = 8'd0;
							else if (prem_q != 8'd0) prem_n = prem_q - 8'd1;
							if (prem_n == 8'd0 && phase_n == PH_PIXEL) phase_n = PH_PACKET;
						end
					end
				end
				PH_SKIP: ;
				default: ;
			endcase
			if (start) begin
				sub_n = '0; cass_n = '0; row_n = '0; col_n = '0;
				left_n = total_q;
				if (total_q == 32'd0) begin
					rq[n[0]] = fin_res(KIND_DONE, show ? w_q : 16'd0, show ? h_q : 16'd0);
					n = n + 2'd1;
					phase_n = PH_SKIP;
				end else begin
					phase_n = type_q[3] ? PH_PACKET : PH_PIXEL;
				end
			end
			if (stream_last) begin
				if (phase_n != PH_SKIP) begin
					rq[n[0]] = (phase_n == PH_HEADER) ? fin_res(KIND_TRUNC, 16'd0, 16'd0)
						: fin_res(KIND_TRUNC, w_q, h_q);
					n = n + 2'd1;
				end
				phase_n = PH_HEADER; hcnt_n = '0; sub_n = '0; ent_n = '0;
				id_n = '0; type_n = '0; cmd_n = '0; pd_n = '0; desc_n = '0;
				cms_n = '0; cml_n = '0; w_n = '0; h_n = '0;
				cass_n = '0; left_n = '0; prem_n = '0; prun_n = 1'b0;
				row_n = '0; col_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hcnt_q <= '0; sub_q <= '0; ent_q <= '0;
			id_q <= '0; type_q <= '0; cmd_q <= '0; pd_q <= '0; desc_q <= '0;
			cms_q <= '0; cml_q <= '0; w_q <= '0; h_q <= '0;
			cass_q <= '0; left_q <= '0; total_q <= '0; prem_q <= '0; prun_q <= 1'b0;
			row_q <= '0; col_q <= '0; cnt_s1 <= '0;
		end else begin
			phase_q <= phase_n; hcnt_q <= hcnt_n; sub_q <= sub_n; ent_q <= ent_n;
			id_q <= id_n; type_q <= type_n; cmd_q <= cmd_n; pd_q <= pd_n; desc_q <= desc_n;
			cms_q <= cms_n; cml_q <= cml_n; w_q <= w_n; h_q <= h_n;
			cass_q <= cass_n; left_q <= left_n; total_q <= w_q * h_q;
			prem_q <= prem_n; prun_q <= prun_n;
			row_q <= row_n; col_q <= col_n; cnt_s1 <= n;
		end
	end

	always_ff @(posedge clk) begin
		r0_s1 <= rq[0];
		r1_s1 <= rq[1];
		pal_s1 <= pal_n;
		palz_s1 <= palz_n;
	end

	always_comb begin
		res0 = r0_s1;
		if (pal_s1) res0.color = palz_s1 ? 32'd0 : pal_rdata;
	end
	assign res1 = r1_s1;
	assign stat.busy = busy;
	assign stat.s1_cnt = cnt_s1;

endmodule

`default_nettype wire

>>> design/tgad_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tga_image_stream_decoder_unit_defines.svh"

module tgad_result_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   push_n,
	input  wire tgad_pkg::res_t               push0,
	input  wire tgad_pkg::res_t               push1,
	output tgad_pkg::res_t                    head,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [tgad_pkg::FIFO_CW-1:0]      cnt
);
	import tgad_pkg::*;

	res_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wp_q, rp_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign head = mem_q[rp_q];
	assign cnt = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wp_q] <= push0;
		if (push_n == 2'd2) mem_q[wp_q + FIFO_AW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + FIFO_AW'(push_n);
			rp_q <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	`TGAD_ASSERT(a_fifo_bound, clk, arst_n, cnt_q <= FIFO_CW'(FIFO_DEPTH), "queue over depth")
	`TGAD_ASSERT_NEVER(a_fifo_room, clk, arst_n, (4'(cnt_q) + 4'(push_n)) > (4'(FIFO_DEPTH) + 4'(pop)), "push without room")
	`TGAD_ASSERT(a_fifo_fill, clk, arst_n, (cnt_q == '0 && push_n != 2'd0) |=> out_valid, "push lost")

endmodule

`default_nettype wire

>>> design/tga_image_stream_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake              payload
// input     in         in_valid / in_stall    data_byte, stream_last
// output    out        out_valid / out_stall  kind, color, dest_row, dest_col, run_length,
//                                             image_width, image_height, last
// One byte per cycle unless stalled; results are registered (decode, palette read), then queued.
// A run ending more than one row past its start stalls input while its column is folded back.
// Input stalls while the four-entry result queue cannot take two more results.
// arst_n clears all control state; the palette memory holds garbage until loaded.

module tga_image_stream_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        stream_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [31:0]      color,
	output logic [15:0]      dest_row,
	output logic [15:0]      dest_col,
	output logic [7:0]       run_length,
	output logic [15:0]      image_width,
	output logic [15:0]      image_height,
	output logic             last
);
	import tgad_pkg::*;

	logic                 in_take;
	logic                 pal_we, pal_re;
	logic [PAL_AW-1:0]    pal_waddr, pal_raddr;
	logic [31:0]          pal_wdata, pal_rdata;
	res_t                 res0, res1, head;
	stat_t                stat;
	logic [FIFO_CW-1:0]   cnt;

	// hold input while busy or while the queue lacks room for two results
	assign in_stall = stat.busy || ((4'(cnt) + 4'(stat.s1_cnt)) > 4'(FIFO_DEPTH - 2));
	assign in_take = in_valid && !in_stall;

	tgad_palette_ram u_ram (
		.clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
		.re(pal_re), .raddr(pal_raddr), .rdata(pal_rdata)
	);

	tgad_parser u_parser (
		.clk(clk), .arst_n(arst_n), .in_take(in_take),
		.data_byte(data_byte), .stream_last(stream_last),
		.pal_we(pal_we), .pal_waddr(pal_waddr), .pal_wdata(pal_wdata),
		.pal_re(pal_re), .pal_raddr(pal_raddr), .pal_rdata(pal_rdata),
		.res0(res0), .res1(res1), .stat(stat)
	);

	tgad_result_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push_n(stat.s1_cnt), .push0(res0), .push1(res1),
		.head(head), .out_valid(out_valid), .out_stall(out_stall), .cnt(cnt)
	);

	assign kind = head.kind;
	assign color = head.color;
	assign dest_row = head.dest_row;
	assign dest_col = head.dest_col;
	assign run_length = head.run_length;
	assign image_width = head.image_width;
	assign image_height = head.image_height;
	assign last = head.last;

endmodule

`default_nettype wire

>>> tb/sv/tb_tga_image_stream_decoder_unit.sv
`timescale 1ns / 1ps

module tb_tga_image_stream_decoder_unit;
	import tgad_pkg::*;

	class tga_scoreboard;
		typedef enum {ST_HEADER, ST_PALETTE, ST_PACKET, ST_PIXEL, ST_SKIP} stage_e;

		stage_e      stage;
		int unsigned cnt;
		logic [7:0]  hdr [16];
		logic [31:0] pal [PALETTE_ENTRIES];
		int unsigned pk_left;
		bit          pk_run;
		logic [31:0] acc;
		int unsigned pos;
		res_t        expq [$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			stage = ST_HEADER;
			cnt = 0;
			foreach (hdr[i]) hdr[i] = 8'h00;
			pk_left = 0;
			pk_run = 0;
			acc = 0;
			pos = 0;
		endfunction

		function int unsigned word(int s);
			return 32'({hdr[s + 1], hdr[s]});
		endfunction

		function int unsigned total_pix();
			return word(12) * word(14);
		endfunction

		function void push(kind_t k, logic [31:0] c, int unsigned row, int unsigned col,
				int unsigned len, bit lst);
			res_t r;
			r = '0;
			r.kind = k;
			r.color = c;
			r.dest_row = row[15:0];
			r.dest_col = col[15:0];
			r.run_length = len[7:0];
			r.image_width = (stage == ST_HEADER) ? 16'h0 : word(12);
			r.image_height = (stage == ST_HEADER) ? 16'h0 : word(14);
			r.last = lst;
			expq.push_back(r);
		endfunction

		function void finish(kind_t k);
			push(k, 0, 0, 0, 0, 1);
			stage = ST_SKIP;
		endfunction

		function void begin_pixels();
			cnt = 0;
			acc = 0;
			pos = 0;
			if (total_pix() == 0)
				finish(KIND_DONE);
			else
				stage = hdr[2][3] ? ST_PACKET : ST_PIXEL;
		endfunction

		function void emit(logic [31:0] c, int unsigned len);
			int unsigned total, w, h, left, row, col, drow;
			total = total_pix();
			w = word(12);
			h = word(14);
			left = total - pos;
			if (len > left)
				len = left;
			row = pos / w;
			col = pos % w;
			drow = hdr[9][5] ? row : (h - 1 - row);
			push(KIND_RUN, c, drow, col, len, 0);
			pos += len;
			if (pos >= total)
				finish(KIND_DONE);
		endfunction

		function void header_done();
			logic [2:0] mode;
			bit         rle, ok;
			logic [7:0] pd;
			mode = hdr[2][2:0] & MODE_MASK;
			rle = hdr[2][3];
			pd = hdr[8];
			ok = (pd == DEPTH_32 && mode == MODE_TRUECOLOR) ||
				(pd == DEPTH_24 && mode == MODE_TRUECOLOR && !rle) ||
				(pd == DEPTH_8 && mode == MODE_CMAP && !rle);
			if (hdr[0] != 0 || !ok) begin
				finish(KIND_HEADER);
				return;
			end
			if (pd == DEPTH_8) begin
				if (word(3) != 0 || word(5) > PALETTE_ENTRIES || hdr[7] != DEPTH_24) begin
					finish(KIND_PALETTE);
					return;
				end
				if (word(5) != 0) begin
					stage = ST_PALETTE;
					cnt = 0;
					acc = 0;
					return;
				end
			end
			begin_pixels();
		endfunction

		function void note_request(logic [7:0] b, bit e);
			int unsigned sub, entry, bpp;
			logic [31:0] c;
			case (stage)
				ST_HEADER: begin
					hdr[cnt == 16 ? 8 : (cnt == 17 ? 9 : cnt)] = b;
					cnt++;
					if (cnt >= HDR_BYTES)
						header_done();
				end
				ST_PALETTE: begin
					sub = cnt % 3;
					entry = cnt / 3;
					acc |= 32'(b) << (8 * sub);
					if (sub == 2) begin
						if (entry < PALETTE_ENTRIES)
							pal[entry] = ALPHA_OPAQUE | acc;
						acc = 0;
					end
					cnt++;
					if (cnt >= 3 * word(5))
						begin_pixels();
				end
				ST_PACKET: begin
					pk_run = b[7];
					pk_left = b[6:0] + 1;
					cnt = 0;
					acc = 0;
					stage = ST_PIXEL;
				end
				ST_PIXEL: begin
					bpp = hdr[8] / 8;
					acc |= 32'(b) << (8 * (cnt & 3));
					cnt++;
					if (cnt >= bpp) begin
						if (hdr[8] == DEPTH_8)
							c = (b < word(5) && b < PALETTE_ENTRIES) ? pal[b] : 32'h0;
						else if (hdr[8] == DEPTH_24)
							c = ALPHA_OPAQUE | (acc & 32'h00FF_FFFF);
						else
							c = acc;
						cnt = 0;
						acc = 0;
						if (hdr[2][3]) begin
							if (pk_run) begin
								emit(c, pk_left);
								pk_left = 0;
							end else begin
								emit(c, 1);
								if (pk_left > 0)
									pk_left--;
							end
							if (pk_left == 0 && stage == ST_PIXEL)
								stage = ST_PACKET;
						end else begin
							emit(c, 1);
						end
					end
				end
				default: ;
			endcase
			if (e) begin
				if (stage != ST_SKIP)
					finish(KIND_TRUNC);
				clear();
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expq.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %p", got);
				return;
			end
			want = expq.pop_front();
			if (got.kind !== want.kind || got.color !== want.color ||
					got.dest_row !== want.dest_row || got.dest_col !== want.dest_col ||
					got.run_length !== want.run_length ||
					got.image_width !== want.image_width ||
					got.image_height !== want.image_height || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        stream_last;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  kind;
	logic [31:0] color;
	logic [15:0] dest_row;
	logic [15:0] dest_col;
	logic [7:0]  run_length;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last;

	tga_scoreboard sb = new();
	logic [7:0]    file_bytes [$];
	bit            burst;
	int            sent_bytes;
	int            rx_count;

	tga_image_stream_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.stream_last(stream_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.color(color),
		.dest_row(dest_row),
		.dest_col(dest_col),
		.run_length(run_length),
		.image_width(image_width),
		.image_height(image_height),
		.last(last)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] pixel_byte(logic [7:0] depth, int pal_len);
		if (depth == DEPTH_8 && $urandom_range(0, 3) != 0)
			return 8'($urandom_range(0, pal_len > 0 ? pal_len - 1 : 0));
		return 8'($urandom);
	endfunction

	task automatic make_image(input logic [7:0] itype, input logic [7:0] depth,
			input int w, input int h, input logic [7:0] desc, input int pal_len);
		int         npix, bpp, done, n;
		logic [7:0] pk;
		file_bytes.delete();
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'($urandom_range(0, 1)));
		file_bytes.push_back(itype);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'h00);
		file_bytes.push_back(pal_len[7:0]);
		file_bytes.push_back(pal_len[15:8]);
		file_bytes.push_back(depth == DEPTH_8 ? DEPTH_24 : 8'($urandom));
		repeat (4) file_bytes.push_back(8'($urandom));
		file_bytes.push_back(w[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(depth);
		file_bytes.push_back(desc);
		if (depth == DEPTH_8 && pal_len <= PALETTE_ENTRIES)
			repeat (3 * pal_len) file_bytes.push_back(8'($urandom));
		npix = w * h;
		if (npix > 64)
			npix = 64;
		bpp = depth / 8;
		if (bpp == 0)
			bpp = 1;
		if (itype[3]) begin
			done = 0;
			while (done < npix) begin
				pk = 8'($urandom);
				if (!pk[7] && pk[6:0] > 7'd7)
					pk[6:0] = 7'($urandom_range(0, 7));
				if ($urandom_range(0, 7) == 0)
					pk = 8'hFF;
				n = pk[6:0] + 1;
				file_bytes.push_back(pk);
				repeat (pk[7] ? bpp : n * bpp) file_bytes.push_back(8'($urandom));
				done += n;
			end
		end else begin
			repeat (npix * bpp) file_bytes.push_back(pixel_byte(depth, pal_len));
		end
	endtask

	task automatic send_file(input int cut, input int junk);
		int gap;
		if (cut > 0 && cut < file_bytes.size())
			file_bytes = file_bytes[0:cut - 1];
		repeat (junk) file_bytes.push_back(8'($urandom));
		foreach (file_bytes[i]) begin
			gap = burst ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= file_bytes[i];
			stream_last <= (i == file_bytes.size() - 1);
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			sb.note_request(file_bytes[i], i == file_bytes.size() - 1);
			sent_bytes++;
		end
	endtask

	task automatic random_image();
		int         sel, w, h, pl;
		logic [7:0] hi;
		sel = $urandom_range(0, 9);
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 4);
		pl = $urandom_range(1, 8);
		hi = 8'($urandom_range(0, 15)) << 4;
		case ($urandom_range(0, 3))
			0: make_image(hi | 8'h02, DEPTH_32, w, h, 8'($urandom), 0);
			1: make_image(hi | 8'h0A, DEPTH_32, w, h, 8'($urandom), 0);
			2: make_image(hi | 8'h02, DEPTH_24, w, h, 8'($urandom), 0);
			default: make_image(hi | 8'h01, DEPTH_8, w, h, 8'($urandom), pl);
		endcase
		if (sel == 0) begin
			foreach (file_bytes[i]) file_bytes[i] = 8'($urandom);
			send_file(0, 0);
		end else if (sel == 1) begin
			send_file($urandom_range(1, file_bytes.size() - 1), 0);
		end else begin
			send_file(0, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		stream_last = 1'b0;
		burst = 1'b0;
		sent_bytes = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		make_image(8'h02, DEPTH_32, 2, 2, 8'h20, 0); send_file(0, 0);
		make_image(8'h0A, DEPTH_32, 3, 2, 8'h00, 0); send_file(0, 0);
		make_image(8'h02, DEPTH_24, 2, 2, 8'hFF, 0); send_file(0, 0);
		make_image(8'h01, DEPTH_8, 3, 2, 8'h20, 4); send_file(0, 0);
		make_image(8'h02, DEPTH_32, 65535, 0, 8'h00, 0); send_file(0, 0);
		make_image(8'h02, DEPTH_24, 0, 65535, 8'h00, 0); send_file(0, 0);
		make_image(8'h01, DEPTH_8, 2, 1, 8'h00, 0); send_file(0, 0);
		make_image(8'hF1, DEPTH_8, 2, 2, 8'h20, 256); send_file(40, 0);
		make_image(8'h01, DEPTH_8, 2, 1, 8'h00, 257); send_file(0, 0);
		make_image(8'h01, DEPTH_8, 2, 1, 8'h00, 2);
		file_bytes[3] = 8'h01;
		send_file(0, 0);
		make_image(8'h01, DEPTH_8, 2, 1, 8'h00, 2);
		file_bytes[7] = 8'd16;
		send_file(0, 0);
		make_image(8'h02, DEPTH_32, 1, 1, 8'h00, 0);
		file_bytes[0] = 8'hFF;
		send_file(0, 0);
		make_image(8'h03, DEPTH_32, 1, 1, 8'h00, 0); send_file(0, 0);
		make_image(8'h0A, DEPTH_24, 1, 1, 8'h00, 0); send_file(0, 0);
		make_image(8'h09, DEPTH_8, 1, 1, 8'h00, 2); send_file(0, 0);
		make_image(8'h02, 8'd16, 1, 1, 8'h00, 0); send_file(0, 0);
		make_image(8'h02, DEPTH_32, 2, 2, 8'h00, 0); send_file(10, 0);
		make_image(8'h02, DEPTH_32, 2, 2, 8'h00, 0); send_file(25, 0);
		make_image(8'h02, DEPTH_24, 1, 2, 8'h20, 0); send_file(0, 5);
		make_image(8'h0A, DEPTH_32, 4, 2, 8'h20, 0);
		file_bytes[18] = 8'hFF;
		send_file(0, 3);
		burst = 1'b1;
		make_image(8'h0A, DEPTH_32, 6, 4, 8'h00, 0); send_file(0, 0);

		while (sent_bytes < 650) begin
			burst = ($urandom_range(0, 4) == 0);
			random_image();
		end
		in_valid <= 1'b0;
		stream_last <= 1'b0;

		while (sb.expq.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.expq.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("tb_tga_image_stream_decoder_unit: PASS");
		else
			$display("tb_tga_image_stream_decoder_unit: FAIL");
		$finish;
	end

	initial begin
		int  k;
		bit  held;
		out_stall = 1'b1;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && rx_count >= 40) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			k = burst ? 0 : $urandom_range(0, 19);
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
		end
	end

	initial rx_count = 0;

	always @(posedge clk) begin
		res_t r;
		if (arst_n && out_valid && !out_stall) begin
			r.kind = kind_t'(kind);
			r.color = color;
			r.dest_row = dest_row;
			r.dest_col = dest_col;
			r.run_length = run_length;
			r.image_width = image_width;
			r.image_height = image_height;
			r.last = last;
			sb.check_result(r);
			rx_count++;
		end
	end

	initial begin
		#2_000_000;
		$display("tb_tga_image_stream_decoder_unit: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/tgad_pkg.sv
design/tgad_palette_ram.sv
design/tgad_parser.sv
design/tgad_result_fifo.sv
design/tga_image_stream_decoder_unit.sv
tb/sv/tb_tga_image_stream_decoder_unit.sv
